// ===== sv/muh_pkg.sv =====
// ----------------------------------------------------------------------------
// muh_pkg
// Types and constants shared by the mission upload handshake unit.
// ----------------------------------------------------------------------------
package muh_pkg;

    // Input transaction types
    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_START   = 2'd1,
        REQ_REQUEST = 2'd2,
        REQ_ACK     = 2'd3
    } t_req;

    // Result actions
    typedef enum logic [2:0] {
        ACT_NONE        = 3'd0,
        ACT_CLEAR_ALL   = 3'd1,
        ACT_COUNT       = 3'd2,
        ACT_ITEM        = 3'd3,
        ACT_SET_CURRENT = 3'd4
    } t_action;

    // Upload status codes
    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_PROGRESS = 2'd1,
        ST_COMPLETE = 2'd2,
        ST_FAILED   = 2'd3
    } t_status;

    // Configuration register indexes
    localparam logic [1:0] REG_MAX_RETRIES   = 2'd0;
    localparam logic [1:0] REG_BASE_BACKOFF  = 2'd1;
    localparam logic [1:0] REG_RESPONSE_WAIT = 2'd2;
    localparam logic [1:0] REG_UPLOAD_TMO    = 2'd3;

    // Configuration reset values
    localparam logic [3:0]  CFG_MAX_RETRIES_RST   = 4'd10;
    localparam logic [11:0] CFG_BASE_BACKOFF_RST  = 12'd500;
    localparam logic [15:0] CFG_RESPONSE_WAIT_RST = 16'd2000;
    localparam logic [19:0] CFG_UPLOAD_TMO_RST    = 20'd20000;

    // No sequence seen yet, and saturation point of the tick counter
    localparam logic [15:0] SEQ_NONE    = 16'hFFFF;
    localparam logic [19:0] ELAPSED_MAX = 20'hFFFFF;

    typedef struct packed {
        logic [3:0]  max_retries;
        logic [11:0] base_backoff;
        logic [15:0] response_wait;
        logic [19:0] upload_timeout;
    } t_cfg;

    typedef struct packed {
        t_action     action;
        logic [15:0] item_seq;
        logic        item_is_first;
        logic [15:0] count_value;
        t_status     upload_status;
        logic [16:0] items_done;
        logic        last_result;
    } t_result;

    // Results of one accepted transaction: zero, one or two of them
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_step;

endpackage

// ===== sv/muh_core.sv =====
// ----------------------------------------------------------------------------
// muh_core
// Upload state registers and the single-pass update that produces the
// results of one accepted transaction.
// ----------------------------------------------------------------------------
module muh_core
    import muh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_waypoint_count,
    input  logic [15:0] i_request_seq,
    input  logic [7:0]  i_ack_result,
    input  t_cfg        i_cfg,
    output t_step       o_step
);

    logic        r_started, n_started;
    logic        r_complete, n_complete;
    logic        r_failed, n_failed;
    logic        r_pending, n_pending;
    logic [3:0]  r_retry, n_retry;
    logic [16:0] r_sent, n_sent;
    logic [15:0] r_last_seq, n_last_seq;
    logic [15:0] r_wait, n_wait;
    logic [19:0] r_elapsed, n_elapsed;
    logic [15:0] r_total, n_total;

    logic        w_active;
    logic        w_send;
    logic [15:0] w_wait_dec;
    logic [1:0]  w_num;
    t_action     w_act0, w_act1;
    t_status     w_status;
    t_req        w_req;

    function automatic t_result f_result(t_action act, logic [15:0] seq, logic [15:0] total,
                                         t_status st, logic [16:0] done, logic last);
        t_result r;
        r.action        = act;
        r.item_seq      = (act == ACT_ITEM) ? seq : 16'd0;
        r.item_is_first = (act == ACT_ITEM) && (seq == 16'd0);
        r.count_value   = (act == ACT_COUNT) ? total : 16'd0;
        r.upload_status = st;
        r.items_done    = done;
        r.last_result   = last;
        return r;
    endfunction

    assign w_active   = r_started && !r_complete;
    assign w_req      = t_req'(i_req_type);
    assign w_wait_dec = (r_wait != 16'd0) ? (r_wait - 16'd1) : 16'd0;
    assign w_send     = (w_wait_dec == 16'd0) && (r_retry < i_cfg.max_retries) && !r_pending;

    // Compute next state and the actions of this transaction
    always_comb begin
        n_started  = r_started;
        n_complete = r_complete;
        n_failed   = r_failed;
        n_pending  = r_pending;
        n_retry    = r_retry;
        n_sent     = r_sent;
        n_last_seq = r_last_seq;
        n_wait     = r_wait;
        n_elapsed  = r_elapsed;
        n_total    = r_total;
        w_num      = 2'd0;
        w_act0     = ACT_NONE;
        w_act1     = ACT_NONE;
        case (w_req)
            REQ_TICK: begin
                if (w_active && !r_failed) begin
                    n_elapsed = (r_elapsed != ELAPSED_MAX) ? (r_elapsed + 20'd1) : r_elapsed;
                    n_wait    = w_wait_dec;
                    if (w_send) begin
                        n_retry = r_retry + 4'd1;
                        n_wait  = {4'd0, i_cfg.base_backoff} * {12'd0, n_retry};
                        w_num   = 2'd1;
                        w_act0  = ACT_COUNT;
                    end
                    if (n_elapsed >= i_cfg.upload_timeout) begin
                        n_failed = 1'b1;
                        if (!w_send) begin
                            w_num  = 2'd1;
                            w_act0 = ACT_NONE;
                        end
                    end
                end
            end
            REQ_START: begin
                if (!r_started) begin
                    n_started  = 1'b1;
                    n_complete = 1'b0;
                    n_failed   = 1'b0;
                    n_sent     = 17'd0;
                    n_retry    = 4'd0;
                    n_elapsed  = 20'd0;
                    n_wait     = i_cfg.response_wait;
                    n_pending  = 1'b0;
                    n_total    = i_waypoint_count;
                    w_num      = 2'd2;
                    w_act0     = ACT_CLEAR_ALL;
                    w_act1     = ACT_COUNT;
                end
            end
            REQ_REQUEST: begin
                n_pending = 1'b1;
                if (w_active && (i_request_seq != r_last_seq)) begin
                    n_last_seq = i_request_seq;
                    n_pending  = 1'b0;
                    w_num      = 2'd1;
                    if (i_request_seq < r_total) begin
                        n_wait = i_cfg.response_wait;
                        n_sent = {1'b0, i_request_seq} + 17'd1;
                        w_act0 = ACT_ITEM;
                    end else begin
                        n_wait = {4'd0, i_cfg.base_backoff};
                        w_act0 = ACT_COUNT;
                    end
                end
            end
            REQ_ACK: begin
                if (w_active && (r_sent >= {1'b0, r_total})) begin
                    n_last_seq = SEQ_NONE;
                    w_num      = 2'd1;
                    if (i_ack_result == 8'd0) begin
                        n_complete = 1'b1;
                        w_act0     = ACT_SET_CURRENT;
                    end else begin
                        n_failed = 1'b1;
                        w_act0   = ACT_NONE;
                    end
                end
            end
            default: begin
                w_num = 2'd0;
            end
        endcase
    end

    // Derive the status seen after this transaction
    always_comb begin
        if (n_complete) begin
            w_status = ST_COMPLETE;
        end else if (n_failed) begin
            w_status = ST_FAILED;
        end else if (n_started) begin
            w_status = ST_PROGRESS;
        end else begin
            w_status = ST_IDLE;
        end
    end

    // Pack the result transactions
    always_comb begin
        o_step.num  = w_num;
        o_step.res0 = f_result(w_act0, i_request_seq, n_total, w_status, n_sent,
                               w_num == 2'd1);
        o_step.res1 = f_result(w_act1, i_request_seq, n_total, w_status, n_sent, 1'b1);
    end

    // Update state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_complete <= 1'b0;
            r_failed   <= 1'b0;
            r_pending  <= 1'b0;
            r_retry    <= 4'd0;
            r_sent     <= 17'd0;
            r_last_seq <= SEQ_NONE;
            r_wait     <= 16'd0;
            r_elapsed  <= 20'd0;
            r_total    <= 16'd0;
        end else if (i_accept) begin
            r_started  <= n_started;
            r_complete <= n_complete;
            r_failed   <= n_failed;
            r_pending  <= n_pending;
            r_retry    <= n_retry;
            r_sent     <= n_sent;
            r_last_seq <= n_last_seq;
            r_wait     <= n_wait;
            r_elapsed  <= n_elapsed;
            r_total    <= n_total;
        end
    end

endmodule

// ===== sv/mission_upload_handshake_unit.sv =====
// ----------------------------------------------------------------------------
// mission_upload_handshake_unit
// Ground-side mission upload handshake with an APB register port and a
// four-entry result queue.
// ----------------------------------------------------------------------------
// An input transaction is taken whole on acceptance: the upload state is updated
// at the accepting edge and its results (two for a start, otherwise zero or
// one) are written into a four-entry result queue that feeds the output
// channel. The input accepts one transaction per cycle while the queue has at
// least two free entries, so the sustained rate is one per cycle as long as
// the output side drains the queue; the queue depth and the two results of a
// start set when the input stalls. Registers sit at byte addresses 0, 4, 8
// and 12 (max_retries, base_backoff_ms, response_wait_ms, upload_timeout_ms)
// and should be written only while the block is idle.
module mission_upload_handshake_unit
    import muh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_waypoint_count,
    input  logic [15:0] i_request_seq,
    input  logic [7:0]  i_ack_result,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_action,
    output logic [15:0] o_item_seq,
    output logic        o_item_is_first,
    output logic [15:0] o_count_value,
    output logic [1:0]  o_upload_status,
    output logic [16:0] o_items_done,
    output logic        o_last_result,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg        r_cfg;
    t_step       w_step;
    t_result     r_queue [4];
    t_result     w_head;
    logic [1:0]  r_wr_ptr, r_rd_ptr;
    logic [2:0]  r_count, n_count;
    logic        w_in_accept;
    logic        w_pop;
    logic        w_cfg_write;

    // Configuration registers
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_retries    <= CFG_MAX_RETRIES_RST;
            r_cfg.base_backoff   <= CFG_BASE_BACKOFF_RST;
            r_cfg.response_wait  <= CFG_RESPONSE_WAIT_RST;
            r_cfg.upload_timeout <= CFG_UPLOAD_TMO_RST;
        end else if (w_cfg_write) begin
            case (paddr[3:2])
                REG_MAX_RETRIES:   r_cfg.max_retries    <= pwdata[3:0];
                REG_BASE_BACKOFF:  r_cfg.base_backoff   <= pwdata[11:0];
                REG_RESPONSE_WAIT: r_cfg.response_wait  <= pwdata[15:0];
                REG_UPLOAD_TMO:    r_cfg.upload_timeout <= pwdata[19:0];
                default:           r_cfg                <= r_cfg;
            endcase
        end
    end

    // Return register contents on read
    always_comb begin
        case (paddr[3:2])
            REG_MAX_RETRIES:   prdata = {28'd0, r_cfg.max_retries};
            REG_BASE_BACKOFF:  prdata = {20'd0, r_cfg.base_backoff};
            REG_RESPONSE_WAIT: prdata = {16'd0, r_cfg.response_wait};
            REG_UPLOAD_TMO:    prdata = {12'd0, r_cfg.upload_timeout};
            default:           prdata = 32'd0;
        endcase
    end

    // Hold the input while fewer than two queue entries are free
    assign o_in_stall  = (r_count > 3'd2);
    assign w_in_accept = i_in_valid && !o_in_stall;

    muh_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_in_accept),
        .i_req_type       (i_req_type),
        .i_waypoint_count (i_waypoint_count),
        .i_request_seq    (i_request_seq),
        .i_ack_result     (i_ack_result),
        .i_cfg            (r_cfg),
        .o_step           (w_step)
    );

    // Write results into the queue
    always_ff @(posedge i_clk) begin
        if (w_in_accept && (w_step.num != 2'd0)) begin
            r_queue[r_wr_ptr] <= w_step.res0;
            if (w_step.num == 2'd2) begin
                r_queue[r_wr_ptr + 2'd1] <= w_step.res1;
            end
        end
    end

    // Advance queue pointers and count
    assign w_pop   = o_out_valid && !i_out_stall;
    assign n_count = r_count + (w_in_accept ? {1'b0, w_step.num} : 3'd0)
                             - {2'd0, w_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (w_in_accept) begin
                r_wr_ptr <= r_wr_ptr + w_step.num;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= n_count;
        end
    end

    // Drive the output transaction from the queue head
    assign w_head          = r_queue[r_rd_ptr];
    assign o_out_valid     = (r_count != 3'd0);
    assign o_action        = w_head.action;
    assign o_item_seq      = w_head.item_seq;
    assign o_item_is_first = w_head.item_is_first;
    assign o_count_value   = w_head.count_value;
    assign o_upload_status = w_head.upload_status;
    assign o_items_done    = w_head.items_done;
    assign o_last_result   = w_head.last_result;

    // Queue never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue overflow");

    // An accepted transaction always finds room for two results
    a_room_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |-> (r_count <= 3'd2))
        else $error("input accepted without queue room");

    // A head that is not the final result has its partner queued behind it
    a_partner_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_result) |-> (r_count >= 3'd2))
        else $error("first of two results without its partner");

endmodule

// ===== verif/upload_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upload_scoreboard_pkg
// Scoreboard for the mission upload handshake unit. It keeps its own copy of
// the upload state and registers, works out the results of every accepted
// transaction and checks each result that leaves the block against them.
// ----------------------------------------------------------------------------
package upload_scoreboard_pkg;
    import muh_pkg::*;

    class upload_scoreboard;
        // register copies
        logic [3:0]  max_retries;
        logic [11:0] base_backoff;
        logic [15:0] response_wait;
        logic [19:0] upload_timeout;
        // upload state
        bit          started;
        bit          complete;
        bit          failed;
        bit          req_pending;
        logic [3:0]  retry_count;
        logic [16:0] sent_count;
        logic [15:0] last_seq;
        logic [15:0] retry_wait;
        logic [19:0] elapsed;
        logic [15:0] total_items;
        // results still owed by the block, oldest first
        t_result     expected_q[$];
        t_result     batch[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            reset_state();
        endfunction

        function void reset_state();
            max_retries    = CFG_MAX_RETRIES_RST;
            base_backoff   = CFG_BASE_BACKOFF_RST;
            response_wait  = CFG_RESPONSE_WAIT_RST;
            upload_timeout = CFG_UPLOAD_TMO_RST;
            started        = 1'b0;
            complete       = 1'b0;
            failed         = 1'b0;
            req_pending    = 1'b0;
            retry_count    = '0;
            sent_count     = '0;
            last_seq       = SEQ_NONE;
            retry_wait     = '0;
            elapsed        = '0;
            total_items    = '0;
            expected_q.delete();
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_MAX_RETRIES:   max_retries    = value[3:0];
                REG_BASE_BACKOFF:  base_backoff   = value[11:0];
                REG_RESPONSE_WAIT: response_wait  = value[15:0];
                REG_UPLOAD_TMO:    upload_timeout = value[19:0];
                default: ;
            endcase
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction

        // Queue one message of this transaction; status fields come later
        function void emit_result(t_action act, logic [15:0] seq);
            t_result r;
            r = '0;
            r.action        = act;
            r.item_seq      = (act == ACT_ITEM) ? seq : 16'd0;
            r.item_is_first = (act == ACT_ITEM) && (seq == 16'd0);
            r.count_value   = (act == ACT_COUNT) ? total_items : 16'd0;
            batch.push_back(r);
        endfunction

        // Advance the upload state by one accepted transaction
        function void note_input(t_req kind, logic [15:0] wp, logic [15:0] seq,
                                 logic [7:0] ack);
            bit      active;
            bit      resent;
            t_status st;
            t_result r;
            batch.delete();
            active = started && !complete;
            resent = 1'b0;
            case (kind)
                REQ_TICK: begin
                    if (active && !failed) begin
                        if (elapsed != ELAPSED_MAX) elapsed = elapsed + 20'd1;
                        if (retry_wait != 16'd0) retry_wait = retry_wait - 16'd1;
                        // resend the count with linear backoff
                        if (retry_wait == 16'd0 && retry_count < max_retries &&
                            !req_pending) begin
                            emit_result(ACT_COUNT, 16'd0);
                            retry_count = retry_count + 4'd1;
                            retry_wait  = 16'(int'(base_backoff) * int'(retry_count));
                            resent      = 1'b1;
                        end
                        if (elapsed >= upload_timeout) begin
                            failed = 1'b1;
                            if (!resent) emit_result(ACT_NONE, 16'd0);
                        end
                    end
                end
                REQ_START: begin
                    if (!started) begin
                        started     = 1'b1;
                        complete    = 1'b0;
                        failed      = 1'b0;
                        sent_count  = '0;
                        retry_count = '0;
                        elapsed     = '0;
                        retry_wait  = response_wait;
                        req_pending = 1'b0;
                        total_items = wp;
                        emit_result(ACT_CLEAR_ALL, 16'd0);
                        emit_result(ACT_COUNT, 16'd0);
                    end
                end
                REQ_REQUEST: begin
                    req_pending = 1'b1;
                    if (active && seq != last_seq) begin
                        last_seq    = seq;
                        req_pending = 1'b0;
                        retry_wait  = response_wait;
                        if (seq < total_items) begin
                            emit_result(ACT_ITEM, seq);
                            sent_count = {1'b0, seq} + 17'd1;
                        end else begin
                            emit_result(ACT_COUNT, 16'd0);
                            retry_wait = 16'(base_backoff);
                        end
                    end
                end
                default: begin
                    // ack counts only once every item has gone out
                    if (active && sent_count >= {1'b0, total_items}) begin
                        last_seq = SEQ_NONE;
                        if (ack == 8'd0) begin
                            complete = 1'b1;
                            emit_result(ACT_SET_CURRENT, 16'd0);
                        end else begin
                            failed = 1'b1;
                            emit_result(ACT_NONE, 16'd0);
                        end
                    end
                end
            endcase

            if (complete) st = ST_COMPLETE;
            else if (failed) st = ST_FAILED;
            else if (started) st = ST_PROGRESS;
            else st = ST_IDLE;

            foreach (batch[k]) begin
                r = batch[k];
                r.upload_status = st;
                r.items_done    = sent_count;
                r.last_result   = (k == batch.size() - 1);
                expected_q.push_back(r);
            end
        endfunction

        task report(string msg);
            $display("%0t ns  mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        endtask

        // Match one result against the oldest expectation
        task check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("result with action %0d and nothing expected",
                                 got.action));
                return;
            end
            want = expected_q.pop_front();
            compare_field("action", 32'(got.action), 32'(want.action));
            compare_field("item_seq", 32'(got.item_seq), 32'(want.item_seq));
            compare_field("item_is_first", 32'(got.item_is_first),
                          32'(want.item_is_first));
            compare_field("count_value", 32'(got.count_value), 32'(want.count_value));
            compare_field("upload_status", 32'(got.upload_status),
                          32'(want.upload_status));
            compare_field("items_done", 32'(got.items_done), 32'(want.items_done));
            compare_field("last_result", 32'(got.last_result), 32'(want.last_result));
        endtask
    endclass

endpackage

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the mission upload handshake unit. One upload runs through
// directed opening steps, four random phases under different register
// settings, and a closing timeout, rejected ack and accepted ack. Both
// channels idle at random; the scoreboard checks every result in order.
// ----------------------------------------------------------------------------
module tb;
    import muh_pkg::*;
    import upload_scoreboard_pkg::*;

    localparam int unsigned RANDOM_PHASES   = 4;
    localparam int unsigned ITEMS_PER_PHASE = 400;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned LONG_HOLD       = 300;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_req_type       = REQ_TICK;
    logic [15:0] i_waypoint_count = '0;
    logic [15:0] i_request_seq    = '0;
    logic [7:0]  i_ack_result     = '0;
    logic        o_out_valid;
    logic        i_out_stall      = 1'b0;
    logic [2:0]  o_action;
    logic [15:0] o_item_seq;
    logic        o_item_is_first;
    logic [15:0] o_count_value;
    logic [1:0]  o_upload_status;
    logic [16:0] o_items_done;
    logic        o_last_result;
    logic        psel             = 1'b0;
    logic        penable          = 1'b0;
    logic        pwrite           = 1'b0;
    logic [3:0]  paddr            = '0;
    logic [31:0] pwdata           = '0;
    logic [31:0] prdata;
    logic        pready;

    upload_scoreboard sb = new();
    bit               steady      = 1'b0;
    int unsigned      hold_cycles = 0;
    logic [15:0]      upload_len;

    mission_upload_handshake_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_waypoint_count (i_waypoint_count),
        .i_request_seq    (i_request_seq),
        .i_ack_result     (i_ack_result),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_action         (o_action),
        .o_item_seq       (o_item_seq),
        .o_item_is_first  (o_item_is_first),
        .o_count_value    (o_count_value),
        .o_upload_status  (o_upload_status),
        .o_items_done     (o_items_done),
        .o_last_result    (o_last_result),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Gap length: mostly none or short, a few long
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Check every result transaction that leaves the block
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.action        = t_action'(o_action);
            got.item_seq      = o_item_seq;
            got.item_is_first = o_item_is_first;
            got.count_value   = o_count_value;
            got.upload_status = t_status'(o_upload_status);
            got.items_done    = o_items_done;
            got.last_result   = o_last_result;
            sb.check_result(got);
        end
    end

    // Result side: random stalls, long hold on request, none while steady
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned free_left;
        stall_left = 0;
        free_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles = hold_cycles - 1;
                i_out_stall <= 1'b1;
            end else if (steady) begin
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (free_left > 0) begin
                    free_left--;
                end else begin
                    free_left  = $urandom_range(0, 12);
                    stall_left = gap_len();
                end
                i_out_stall <= 1'b0;
            end
        end
    end

    // Write one register, then read it back
    task automatic program_reg(logic [1:0] idx, logic [31:0] value);
        logic [31:0] readback;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== value)
            sb.report($sformatf("register %0d reads 0x%0h, wrote 0x%0h",
                                idx, readback, value));
    endtask

    task automatic write_config(logic [3:0] retries, logic [11:0] backoff,
                                logic [15:0] wait_ms, logic [19:0] timeout_ms);
        program_reg(REG_MAX_RETRIES, 32'(retries));
        program_reg(REG_BASE_BACKOFF, 32'(backoff));
        program_reg(REG_RESPONSE_WAIT, 32'(wait_ms));
        program_reg(REG_UPLOAD_TMO, 32'(timeout_ms));
    endtask

    // Drop valid for a gap whose length is n
    task automatic source_gap(int unsigned n);
        if (n > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Present one transaction and hold it until accepted
    task automatic send_item(t_req kind, logic [15:0] wp, logic [15:0] seq,
                             logic [7:0] ack);
        @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_req_type       <= kind;
        i_waypoint_count <= wp;
        i_request_seq    <= seq;
        i_ack_result     <= ack;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(kind, wp, seq, ack);
    endtask

    task automatic offer(t_req kind, logic [15:0] wp, logic [15:0] seq,
                         logic [7:0] ack);
        send_item(kind, wp, seq, ack);
        source_gap(steady ? 0 : gap_len());
    endtask

    // Wait for every owed result, then let the block go quiet
    task automatic settle();
        source_gap(1);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random transaction, kept mostly inside the running upload
    task automatic random_item();
        int unsigned pick;
        logic [15:0] wp;
        logic [15:0] seq;
        logic [7:0]  ack;
        pick = $urandom_range(0, 99);
        wp   = 16'($urandom);
        seq  = 16'($urandom);
        ack  = 8'($urandom);
        if (pick < 45) begin
            offer(REQ_TICK, wp, seq, ack);
        end else if (pick < 50) begin
            offer(REQ_START, wp, seq, ack);
        end else if (pick < 60 && sb.sent_count < {1'b0, sb.total_items}) begin
            // early ack: dropped, keeps the upload alive
            offer(REQ_ACK, wp, seq, ack);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 75) seq = 16'($urandom_range(0, int'(sb.total_items) + 3));
            else if (pick < 85) seq = sb.last_seq;
            else if (pick < 88) seq = sb.total_items - 16'd1;
            offer(REQ_REQUEST, wp, seq, ack);
        end
    endtask

    // Before start, start, ignored starts, first requests and repeats
    task automatic directed_opening();
        upload_len = 16'($urandom_range(40, 300));
        offer(REQ_TICK, 16'hFFFF, 16'hFFFF, 8'hFF);
        offer(REQ_REQUEST, 16'h0000, 16'd5, 8'h00);
        offer(REQ_ACK, 16'h0000, 16'h0000, 8'h00);
        offer(REQ_START, upload_len, 16'h0000, 8'h00);
        offer(REQ_START, 16'hFFFF, 16'h0000, 8'h00);
        offer(REQ_START, 16'h0000, 16'h0000, 8'h00);
        offer(REQ_TICK, 16'h0000, 16'h0000, 8'h00);
        offer(REQ_REQUEST, 16'h0000, 16'd0, 8'h00);
        offer(REQ_ACK, 16'h0000, 16'h0000, 8'hFF);
        offer(REQ_REQUEST, 16'h0000, 16'd0, 8'h00);
        offer(REQ_REQUEST, 16'h0000, upload_len, 8'h00);
        offer(REQ_REQUEST, 16'h0000, 16'hFFFF, 8'h00);
        offer(REQ_REQUEST, 16'h0000, 16'hFFFF, 8'h00);
        offer(REQ_REQUEST, 16'h0000, upload_len - 16'd1, 8'h00);
        offer(REQ_REQUEST, 16'h0000, 16'd1, 8'h00);
    endtask

    // Timeout, service after failure, rejected ack, accepted ack, then dead
    task automatic directed_closing();
        offer(REQ_TICK, 16'h0000, 16'h0000, 8'h00);
        offer(REQ_TICK, 16'h0000, 16'h0000, 8'h00);
        offer(REQ_REQUEST, 16'h0000, 16'd3, 8'h00);
        offer(REQ_REQUEST, 16'h0000, upload_len - 16'd1, 8'h00);
        offer(REQ_ACK, 16'h0000, 16'h0000, 8'd7);
        offer(REQ_REQUEST, 16'h0000, upload_len - 16'd1, 8'h00);
        offer(REQ_ACK, 16'h0000, 16'h0000, 8'd0);
        offer(REQ_TICK, 16'h0000, 16'h0000, 8'h00);
        offer(REQ_REQUEST, 16'h0000, 16'd2, 8'h00);
        offer(REQ_ACK, 16'h0000, 16'h0000, 8'd0);
        offer(REQ_START, 16'h1234, 16'h0000, 8'h00);
    endtask

    initial begin : stimulus
        int unsigned ph;
        int unsigned n;
        // hold reset, release on a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_config(4'd0, 12'd4000, 16'd60000, 20'd1000000);
        directed_opening();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            case (ph)
                0: write_config(4'd4, 12'd0, 16'd0, 20'd1000000);
                1: write_config(4'd9, 12'd3, 16'd10, 20'd1000000);
                2: write_config(4'd15, 12'($urandom_range(0, 20)),
                                16'($urandom_range(0, 50)), 20'd1000000);
                default: write_config(4'($urandom_range(0, 15)),
                                      12'($urandom_range(0, 40)),
                                      16'($urandom_range(0, 100)), 20'd1000000);
            endcase
            steady = (ph == 2);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // long receiver hold while the sender keeps offering
                if (ph == 1 && n == 100) hold_cycles = LONG_HOLD;
                // sender pause until the block has drained
                if (ph == 3 && n == 200) begin
                    source_gap(1);
                    while (sb.outstanding() != 0) @(posedge i_clk);
                end
                random_item();
            end
            steady = 1'b0;
        end

        settle();
        write_config(4'd15, 12'd4000, 16'd60000, 20'd0);
        directed_closing();
        settle();

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("mission_upload_handshake_unit regression: pass");
        else
            $display("mission_upload_handshake_unit regression: fail");
        $finish;
    end

    // Run limit
    initial begin
        #8_000_000;
        $display("mission_upload_handshake_unit regression: fail");
        $finish;
    end

endmodule
